FILE: design/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent in the same cycle
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent true implies consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/tlfq_pkg.sv
// shared constants and types for the two-level feedback queue picker
`default_nettype none

package tlfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PID_BITS    = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int QUANTUM_W   = 16;
    localparam int USED_W      = 16;
    localparam int DRAW_W      = 4;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;
    localparam logic [DRAW_W-1:0]    DRAW_SPLIT    = 4'd8;

    typedef logic [PID_BITS-1:0] pid_t;

    // outgoing task state codes
    typedef enum logic [1:0] {
        TS_READY    = 2'd0,
        TS_BLOCKED  = 2'd1,
        TS_FINISHED = 2'd2,
        TS_OTHER    = 2'd3
    } task_state_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEL  = 3'b010,
        ST_DONE = 3'b100
    } fsm_t;

    // queue requests from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
        pid_t push_pid;
    } queue_ctrl_t;

    // queue status back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

`default_nettype wire

FILE: design/tlfq_ram.sv
// generic single write port ram with registered read
`default_nettype none

module tlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/tlfq_queue.sv
// one circular task id queue: ram storage plus head and occupancy
`default_nettype none

module tlfq_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tlfq_pkg::queue_ctrl_t ctrl,
    output tlfq_pkg::queue_stat_t     stat,
    output tlfq_pkg::pid_t            rd_pid
);

    import tlfq_pkg::*;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W:0]   tail_sum;
    logic [CNT_W:0]   tail_wrap;
    logic [IDX_W-1:0] tail_idx;

    // write position is head plus occupancy, wrapped once
    always_comb
    begin
        tail_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
        tail_wrap = tail_sum - (CNT_W + 1)'(QUEUE_DEPTH);
        if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
        begin
            tail_idx = tail_wrap[IDX_W-1:0];
        end
        else
        begin
            tail_idx = tail_sum[IDX_W-1:0];
        end
    end

    // head and occupancy update
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            if (head_reg == IDX_W'(QUEUE_DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + 1'b1;
            end
        end
        case ({ctrl.push, ctrl.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    // task id storage
    tlfq_ram #(
        .WIDTH (PID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctrl.push),
        .wr_addr (tail_idx),
        .wr_data (ctrl.push_pid),
        .rd_en   (ctrl.pop),
        .rd_addr (head_reg),
        .rd_data (rd_pid)
    );

endmodule

`default_nettype wire

FILE: design/two_level_feedback_queue_picker.sv
// two-level feedback queue picker top level: sequencer, queues and output register
//
// usage
//   input channel (in_valid/in_stall) carries one scheduling call: an optional
//   outgoing task (has_current, current_pid, current_state, used_ticks) and a draw.
//   the outgoing task is pushed to the first queue when 2*used_ticks > quantum,
//   to the second otherwise; finished tasks are reported, other states flagged.
//   then one task is popped: first queue when draw < 8 or the second is empty.
//   output channel (out_valid/out_stall) carries exactly one result per call.
//   quantum: write cfg_wr_en/cfg_wr_data only while the block is idle; unenforced.
// sequence
//   the push lands in the queue ram on the transfer edge, the pop read is issued
//   from the select state and its registered data lands in the output register
//   from the done state. a call goes push, ram read, output load, and no new call
//   is taken until the last one has left the done state.
// reset
//   both queues empty, quantum back to 10, no result pending; ram contents
//   are not cleared since only written entries are ever read.
// stall
//   in_stall is high while a call is in flight; a result waiting under out_stall
//   keeps the next call in the done state, so the input backs up behind it.
`default_nettype none

module two_level_feedback_queue_picker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [15:0]                cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       has_current,
    input  wire logic [7:0]                 current_pid,
    input  wire logic [1:0]                 current_state,
    input  wire logic [15:0]                used_ticks,
    input  wire logic [3:0]                 draw,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            selected_valid,
    output logic [7:0]                      selected_pid,
    output logic                            selected_from,
    output logic                            retired_valid,
    output logic [7:0]                      retired_pid,
    output logic                            state_error,
    output logic                            push_dropped
);

    import tlfq_pkg::*;

    fsm_t                  state_reg, state_next;
    logic [QUANTUM_W-1:0]  quantum_reg;
    logic                  accept;
    task_state_t           cur_st;
    logic                  do_push, do_retire, do_err;
    logic                  to_first, tgt_full;
    pid_t                  in_pid;
    queue_ctrl_t           q1_ctrl, q2_ctrl;
    queue_stat_t           q1_stat, q2_stat;
    pid_t                  q1_pid, q2_pid;
    logic                  pick_first, pick_second;
    logic                  load_out;

    // per-call registers
    logic [DRAW_W-1:0]     draw_reg;
    logic                  ret_valid_reg;
    pid_t                  ret_pid_reg;
    logic                  err_reg, drop_reg;
    logic                  sel_valid_reg, sel_from_reg;

    // output register
    logic                  out_valid_reg;
    logic                  o_sel_valid_reg, o_sel_from_reg;
    pid_t                  o_sel_pid_reg;
    logic                  o_ret_valid_reg;
    pid_t                  o_ret_pid_reg;
    logic                  o_err_reg, o_drop_reg;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_pid   = current_pid[PID_BITS-1:0];
    assign cur_st   = task_state_t'(current_state);

    // outgoing task decode
    always_comb
    begin
        do_push   = 1'b0;
        do_retire = 1'b0;
        do_err    = 1'b0;
        if (has_current)
        begin
            unique case (cur_st) inside
                TS_READY, TS_BLOCKED: do_push   = 1'b1;
                TS_FINISHED:          do_retire = 1'b1;
                TS_OTHER:             do_err    = 1'b1;
                default:              do_err    = 1'b0;
            endcase
        end
    end

    // feedback threshold: more than half the quantum used
    assign to_first = ({1'b0, used_ticks} << 1) > {1'b0, quantum_reg};
    assign tgt_full = to_first ? q1_stat.full : q2_stat.full;

    // pop choice from post-push occupancy
    assign pick_first  = !q1_stat.empty && ((draw_reg < DRAW_SPLIT) || q2_stat.empty);
    assign pick_second = !pick_first && !q2_stat.empty;

    // queue requests
    always_comb
    begin
        q1_ctrl.push     = accept && do_push && to_first && !q1_stat.full;
        q2_ctrl.push     = accept && do_push && !to_first && !q2_stat.full;
        q1_ctrl.pop      = (state_reg == ST_SEL) && pick_first;
        q2_ctrl.pop      = (state_reg == ST_SEL) && pick_second;
        q1_ctrl.push_pid = in_pid;
        q2_ctrl.push_pid = in_pid;
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SEL;
            ST_SEL:  state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quantum_reg   <= QUANTUM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                quantum_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-call payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            draw_reg      <= draw;
            ret_valid_reg <= do_retire;
            ret_pid_reg   <= do_retire ? in_pid : '0;
            err_reg       <= do_err;
            drop_reg      <= do_push && tgt_full;
        end
        if (state_reg == ST_SEL)
        begin
            sel_valid_reg <= pick_first || pick_second;
            sel_from_reg  <= pick_second;
        end
        if (load_out)
        begin
            o_sel_valid_reg <= sel_valid_reg;
            o_sel_from_reg  <= sel_valid_reg && sel_from_reg;
            if (!sel_valid_reg)
            begin
                o_sel_pid_reg <= '0;
            end
            else if (sel_from_reg)
            begin
                o_sel_pid_reg <= q2_pid;
            end
            else
            begin
                o_sel_pid_reg <= q1_pid;
            end
            o_ret_valid_reg <= ret_valid_reg;
            o_ret_pid_reg   <= ret_pid_reg;
            o_err_reg       <= err_reg;
            o_drop_reg      <= drop_reg;
        end
    end

    // first queue: tasks that used most of their slice
    tlfq_queue u_q1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q1_ctrl),
        .stat   (q1_stat),
        .rd_pid (q1_pid)
    );

    // second queue: tasks that gave up the cpu early
    tlfq_queue u_q2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q2_ctrl),
        .stat   (q2_stat),
        .rd_pid (q2_pid)
    );

    assign out_valid      = out_valid_reg;
    assign selected_valid = o_sel_valid_reg;
    assign selected_pid   = 8'(o_sel_pid_reg);
    assign selected_from  = o_sel_from_reg;
    assign retired_valid  = o_ret_valid_reg;
    assign retired_pid    = 8'(o_ret_pid_reg);
    assign state_error    = o_err_reg;
    assign push_dropped   = o_drop_reg;

endmodule

`default_nettype wire

FILE: design/tlfq_checker.sv
// port-level checks for the two-level feedback queue picker, bound to the top
`default_nettype none

`include "assert_macros.svh"

module tlfq_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       selected_valid,
    input wire logic [7:0] selected_pid,
    input wire logic       selected_from,
    input wire logic       retired_valid,
    input wire logic [7:0] retired_pid,
    input wire logic       state_error,
    input wire logic       push_dropped
);

    // one call in flight: busy right after an input transfer
    `CHK_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && !in_stall, in_stall)

    // a stalled result holds
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(selected_pid))

    // no selection means zero id and first queue
    `CHK_SAME(a_sel_zero, clk, rst_n, out_valid && !selected_valid, selected_pid == 8'd0 && !selected_from)

    // no retire means zero retired id
    `CHK_SAME(a_ret_zero, clk, rst_n, out_valid && !retired_valid, retired_pid == 8'd0)

    // the outgoing task takes at most one path
    `CHK_SAME(a_one_path, clk, rst_n, out_valid, $countones({retired_valid, state_error, push_dropped}) <= 1)

endmodule

bind two_level_feedback_queue_picker tlfq_checker u_tlfq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .selected_valid (selected_valid),
    .selected_pid   (selected_pid),
    .selected_from  (selected_from),
    .retired_valid  (retired_valid),
    .retired_pid    (retired_pid),
    .state_error    (state_error),
    .push_dropped   (push_dropped)
);

`default_nettype wire

FILE: tb/tlfq_pick_checker.sv
// checker for the two-level feedback queue picker: predicts each call's result and compares
`default_nettype none

module tlfq_pick_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        has_current,
    input  wire logic [7:0]  current_pid,
    input  wire logic [1:0]  current_state,
    input  wire logic [15:0] used_ticks,
    input  wire logic [3:0]  draw,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        selected_valid,
    input  wire logic [7:0]  selected_pid,
    input  wire logic        selected_from,
    input  wire logic        retired_valid,
    input  wire logic [7:0]  retired_pid,
    input  wire logic        state_error,
    input  wire logic        push_dropped,
    output int               mismatches,
    output int               outstanding
);

    import tlfq_pkg::*;

    localparam bit FROM_FIRST  = 1'b0;
    localparam bit FROM_SECOND = 1'b1;

    // one result of a scheduling call
    typedef struct packed {
        logic sel_valid;
        pid_t sel_pid;
        logic sel_from;
        logic ret_valid;
        pid_t ret_pid;
        logic err;
        logic dropped;
    } pick_result_t;

    // shadow copy of the two run queues and the quantum
    pid_t                 queue_slot [2][QUEUE_DEPTH];
    logic [IDX_W-1:0]     queue_head [2];
    int                   queue_count [2];
    logic [QUANTUM_W-1:0] quantum_now;

    pick_result_t pending_picks[$];
    pick_result_t want_pick;
    int           result_index;

    // push the outgoing task, then pick the next one to run
    function automatic pick_result_t predict_pick(
        input logic              has,
        input pid_t              pid,
        input task_state_t       st,
        input logic [USED_W-1:0] used,
        input logic [DRAW_W-1:0] drw
    );
        pick_result_t     r;
        bit               target;
        logic [IDX_W-1:0] slot_idx;
        r = '0;
        if (has)
        begin
            case (st)
                TS_READY, TS_BLOCKED:
                begin
                    // more than half the slice used sends the task to the first queue
                    target = ({used, 1'b0} > {1'b0, quantum_now}) ? FROM_FIRST : FROM_SECOND;
                    if (queue_count[target] >= QUEUE_DEPTH)
                    begin
                        r.dropped = 1'b1;
                    end
                    else
                    begin
                        slot_idx = queue_head[target] + IDX_W'(queue_count[target]);
                        queue_slot[target][slot_idx] = pid;
                        queue_count[target]++;
                    end
                end
                TS_FINISHED:
                begin
                    r.ret_valid = 1'b1;
                    r.ret_pid   = pid;
                end
                default:
                begin
                    r.err = 1'b1;
                end
            endcase
        end
        // draw below the split favors the first queue, an empty second queue forces it
        if (queue_count[FROM_FIRST] != 0 && (drw < DRAW_SPLIT || queue_count[FROM_SECOND] == 0))
        begin
            target = FROM_FIRST;
            r.sel_valid = 1'b1;
        end
        else if (queue_count[FROM_SECOND] != 0)
        begin
            target = FROM_SECOND;
            r.sel_valid = 1'b1;
        end
        if (r.sel_valid)
        begin
            r.sel_pid = queue_slot[target][queue_head[target]];
            r.sel_from = target;
            queue_head[target] = queue_head[target] + 1'b1;
            queue_count[target]--;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0h got %0h", result_index, name, want, got);
        end
    endtask

    // watch config, input and output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_now  = QUANTUM_RESET;
            queue_head   = '{default: '0};
            queue_count  = '{default: 0};
            pending_picks.delete();
            mismatches   = 0;
            result_index = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                quantum_now = cfg_wr_data;

            // output transfer checked first so a stray result never meets a fresh expectation
            if (out_valid && !out_stall)
            begin
                if (pending_picks.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no call pending", result_index);
                end
                else
                begin
                    want_pick = pending_picks.pop_front();
                    compare_field("selected_valid", 8'(want_pick.sel_valid), 8'(selected_valid));
                    compare_field("selected_pid", want_pick.sel_pid, selected_pid);
                    compare_field("selected_from", 8'(want_pick.sel_from), 8'(selected_from));
                    compare_field("retired_valid", 8'(want_pick.ret_valid), 8'(retired_valid));
                    compare_field("retired_pid", want_pick.ret_pid, retired_pid);
                    compare_field("state_error", 8'(want_pick.err), 8'(state_error));
                    compare_field("push_dropped", 8'(want_pick.dropped), 8'(push_dropped));
                end
                result_index++;
            end

            if (in_valid && !in_stall)
                pending_picks.push_back(predict_pick(has_current, current_pid,
                    task_state_t'(current_state), used_ticks, draw));

            outstanding <= pending_picks.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// top of the picker testbench: clock, reset, stimulus phases and verdict
`default_nettype none

module testbench;
    import tlfq_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int PHASE_CALLS    = 90;
    localparam int HOLD_CYCLES    = 200;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic        has_current;
    logic [7:0]  current_pid;
    task_state_t current_state;
    logic [15:0] used_ticks;
    logic [3:0]  draw;
    logic        out_valid;
    logic        out_stall;
    logic        selected_valid;
    logic [7:0]  selected_pid;
    logic        selected_from;
    logic        retired_valid;
    logic [7:0]  retired_pid;
    logic        state_error;
    logic        push_dropped;

    int          mismatches;
    int          outstanding;
    idle_mode_t  idle_mode;
    bit          hold_request;
    int          hold_left;
    int          calls_sent;
    int unsigned quantum_set;
    int unsigned phase_quantum [8];

    two_level_feedback_queue_picker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .has_current    (has_current),
        .current_pid    (current_pid),
        .current_state  (current_state),
        .used_ticks     (used_ticks),
        .draw           (draw),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .selected_valid (selected_valid),
        .selected_pid   (selected_pid),
        .selected_from  (selected_from),
        .retired_valid  (retired_valid),
        .retired_pid    (retired_pid),
        .state_error    (state_error),
        .push_dropped   (push_dropped)
    );

    tlfq_pick_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .has_current    (has_current),
        .current_pid    (current_pid),
        .current_state  (current_state),
        .used_ticks     (used_ticks),
        .draw           (draw),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .selected_valid (selected_valid),
        .selected_pid   (selected_pid),
        .selected_from  (selected_from),
        .retired_valid  (retired_valid),
        .retired_pid    (retired_pid),
        .state_error    (state_error),
        .push_dropped   (push_dropped),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return 62;
            IDLE_BOTH:   return 19;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 62;
            IDLE_BOTH:     return 19;
            default:       return 0;
        endcase
    endfunction

    // receiver side: random stalls, plus a long hold when asked
    initial
    begin
        out_stall <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
            end
        end
    end

    // offer one call and wait for its transfer
    task automatic offer_call(
        input logic        has,
        input logic [7:0]  pid,
        input task_state_t st,
        input logic [15:0] used,
        input logic [3:0]  drw
    );
        while ($urandom_range(0, 99) < sender_idle_pct())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        has_current   <= has;
        current_pid   <= pid;
        current_state <= st;
        used_ticks    <= used;
        draw          <= drw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        calls_sent++;
    endtask

    // random call handing back a task, with ticks near the feedback threshold in one case of four
    task automatic offer_random_call();
        int          pick;
        int          used;
        task_state_t st;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            st = TS_READY;
        else if (pick < 7)
            st = TS_BLOCKED;
        else if (pick < 9)
            st = TS_FINISHED;
        else
            st = TS_OTHER;
        case ($urandom_range(0, 3))
            0: used = int'(quantum_set >> 1) + $urandom_range(0, 2) - 1;
            1: used = $urandom_range(0, 65535);
            2: used = $urandom_range(0, 3);
            default: used = $urandom_range(0, 1) ? $urandom_range(65520, 65535) : 32768;
        endcase
        if (used < 0)
            used = 0;
        if (used > 65535)
            used = 65535;
        offer_call($urandom_range(0, 9) != 0, 8'($urandom_range(0, 255)), st,
            16'(used), 4'($urandom_range(0, 15)));
    endtask

    // let every pending result drain, then write a new quantum
    task automatic write_quantum(input int unsigned value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 16'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        quantum_set = value;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        in_valid      <= 1'b0;
        has_current   <= 1'b0;
        current_pid   <= '0;
        current_state <= TS_READY;
        used_ticks    <= '0;
        draw          <= '0;
        hold_request  = 1'b0;
        idle_mode     = IDLE_NONE;
        calls_sent    = 0;
        quantum_set   = QUANTUM_RESET;
        phase_quantum = '{1, 65535, 0, $urandom_range(2, 65534), 10,
                          $urandom_range(2, 200), 32768, 2};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed calls under the reset quantum
        offer_call(1'b0, 8'hff, TS_OTHER, 16'hffff, 4'd0);
        offer_call(1'b0, 8'h00, TS_FINISHED, 16'h0000, 4'd15);
        offer_call(1'b1, 8'h00, TS_READY, 16'd0, 4'd0);
        offer_call(1'b1, 8'hff, TS_READY, 16'd6, 4'd7);
        offer_call(1'b1, 8'h55, TS_BLOCKED, 16'd5, 4'd8);
        offer_call(1'b1, 8'haa, TS_BLOCKED, 16'hffff, 4'd9);
        offer_call(1'b1, 8'h81, TS_READY, 16'h8000, 4'd15);
        offer_call(1'b1, 8'h7e, TS_READY, 16'd4, 4'd10);
        offer_call(1'b1, 8'hff, TS_FINISHED, 16'hffff, 4'd3);
        offer_call(1'b1, 8'h00, TS_FINISHED, 16'd0, 4'd12);
        offer_call(1'b1, 8'h3c, TS_OTHER, 16'd20, 4'd1);
        offer_call(1'b1, 8'hc3, TS_OTHER, 16'd0, 4'd14);
        offer_call(1'b0, 8'h12, TS_READY, 16'd100, 4'd5);
        offer_call(1'b1, 8'h01, TS_BLOCKED, 16'd1, 4'd11);
        offer_call(1'b1, 8'hfe, TS_READY, 16'h7fff, 4'd13);
        offer_call(1'b1, 8'h80, TS_BLOCKED, 16'd3, 4'd2);

        // random phases, each under its own quantum and idle pattern
        for (int p = 0; p < 8; p++)
        begin
            write_quantum(phase_quantum[p]);
            idle_mode = idle_mode_t'(p % 4);
            repeat (PHASE_CALLS) offer_random_call();
        end

        // long output hold while calls keep coming, so the input backs up
        idle_mode = IDLE_NONE;
        hold_request = 1'b1;
        repeat (40) offer_random_call();
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d calls across 9 quantum settings incl. 0, 1 and 65535,",
            calls_sent);
        $display("four idle/stall patterns and one long output hold");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 4);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/tlfq_pkg.sv
design/tlfq_ram.sv
design/tlfq_queue.sv
design/two_level_feedback_queue_picker.sv
design/tlfq_checker.sv
tb/tlfq_pick_checker.sv
tb/testbench.sv
